>>> src/brqbd_pkg.sv
// Shared types and constants for the bounded ring queue with batch dequeue.
// No dependencies; imported by every module of the block.
package brqbd_pkg;

  localparam int unsigned DEF_DEPTH     = 256;
  localparam int unsigned DEF_WORD_BITS = 64;
  localparam int unsigned DEF_MAX_BATCH = 64;

  localparam int unsigned OPC_W  = 3;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned LIM_W  = 7;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned STAT_W = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(256);

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [OPC_W-1:0] {
    OP_ENQ   = 3'd0,
    OP_DEQ   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_BATCH = 3'd3,
    OP_SIZE  = 3'd4
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [LIM_W-1:0] lim;
  } cmd_t;

endpackage

>>> src/brqbd_front.sv
// Front end: accepts commands, decodes the opcode, saturates the batch limit
// and holds up to two decoded commands for the back end. Depends on brqbd_pkg.
module brqbd_front import brqbd_pkg::*; #(
  parameter int unsigned WORD_BITS = DEF_WORD_BITS,
  parameter int unsigned MAX_BATCH = DEF_MAX_BATCH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [OPC_W-1:0]     opcode_i,
  input  logic [WORD_W-1:0]    push_word_i,
  input  logic [LIM_W-1:0]     batch_limit_i,
  output logic                 busy_o,
  input  logic                 pop_i,
  output logic                 cmd_valid_o,
  output cmd_t                 cmd_o,
  output logic [WORD_BITS-1:0] word_o
);

  cmd_t                 slot_cmd_q  [2];
  logic [WORD_BITS-1:0] slot_word_q [2];
  logic                 wp_q, rp_q;
  logic [1:0]           cnt_q, cnt_d;
  logic                 accept;
  cmd_t                 cmd_in;

  always_comb begin
    cmd_in.op = OP_SIZE;
    unique case (opcode_i)
      OP_ENQ:   cmd_in.op = OP_ENQ;
      OP_DEQ:   cmd_in.op = OP_DEQ;
      OP_PEEK:  cmd_in.op = OP_PEEK;
      OP_BATCH: cmd_in.op = OP_BATCH;
      default:  cmd_in.op = OP_SIZE;
    endcase
    if (32'(batch_limit_i) > MAX_BATCH) begin
      cmd_in.lim = LIM_W'(MAX_BATCH);
    end else begin
      cmd_in.lim = batch_limit_i;
    end
  end

  assign busy_o      = cnt_q[1];
  assign accept      = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_cmd_q[rp_q];
  assign word_o      = slot_word_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (accept && !(pop_i && cmd_valid_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!accept && pop_i && cmd_valid_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        wp_q <= ~wp_q;
      end
      if (pop_i && cmd_valid_o) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_cmd_q[wp_q]  <= cmd_in;
      slot_word_q[wp_q] <= push_word_i[WORD_BITS-1:0];
    end
  end

endmodule

>>> src/brqbd_back.sv
// Back end: ring-buffer store, head/tail/occupancy, capacity register and the
// execution sequencer that produces results. Depends on brqbd_pkg.
module brqbd_back import brqbd_pkg::*; #(
  parameter int unsigned DEPTH     = DEF_DEPTH,
  parameter int unsigned WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  input  logic                 cmd_valid_i,
  input  cmd_t                 cmd_i,
  input  logic [WORD_BITS-1:0] word_i,
  output logic                 pop_o,
  output logic                 res_valid_o,
  output logic [STAT_W-1:0]    status_o,
  output logic [WORD_W-1:0]    item_word_o,
  output logic [CNT_W-1:0]     count_o,
  output logic                 last_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NXT_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic                 state_q, state_d;
  logic [CNT_W-1:0]     cap_q, cap_d, cap_use;
  logic [IDX_W-1:0]     head_q, head_d, tail_q, tail_d, head_nxt, tail_nxt;
  logic [CNT_W-1:0]     occ_q, occ_d;
  op_e                  kind_q, kind_d;
  logic [LIM_W-1:0]     rem_q, rem_d, removed_q, removed_d, removed_n;
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_q;
  logic                 mem_we, rd_en, stop;
  logic [IDX_W-1:0]     rd_addr;

  logic                 res_valid_d, res_valid_q, last_d, last_q;
  logic [STAT_W-1:0]    status_d, status_q;
  logic [WORD_W-1:0]    word_d, word_q;
  logic [CNT_W-1:0]     count_d, count_q;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cap);
    logic [NXT_W-1:0] n;
    n = NXT_W'(idx) + NXT_W'(1);
    wrap_inc = (n >= NXT_W'(cap)) ? '0 : n[IDX_W-1:0];
  endfunction

  always_comb begin
    if (cap_q == '0) begin
      cap_use = CNT_W'(1);
    end else if (32'(cap_q) > DEPTH) begin
      cap_use = CNT_W'(DEPTH);
    end else begin
      cap_use = cap_q;
    end
  end

  assign head_nxt  = wrap_inc(head_q, cap_use);
  assign tail_nxt  = wrap_inc(tail_q, cap_use);
  assign removed_n = removed_q + LIM_W'(1);
  assign stop      = (rd_q == '0) || (rem_q == LIM_W'(1));

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    kind_d      = kind_q;
    rem_d       = rem_q;
    removed_d   = removed_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    res_valid_d = 1'b0;
    status_d    = ST_OK;
    word_d      = '0;
    count_d     = occ_q;
    last_d      = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.op) inside
            OP_ENQ: begin
              res_valid_d = 1'b1;
              if (occ_q >= cap_use) begin
                status_d = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                tail_d  = tail_nxt;
                occ_d   = occ_q + CNT_W'(1);
                count_d = occ_q + CNT_W'(1);
              end
            end
            OP_DEQ, OP_PEEK, OP_BATCH: begin
              if (occ_q == '0) begin
                res_valid_d = 1'b1;
                status_d    = ST_EMPTY;
                count_d     = '0;
              end else if (cmd_i.op == OP_BATCH && cmd_i.lim == '0) begin
                res_valid_d = 1'b1;
                count_d     = '0;
              end else begin
                rd_en     = 1'b1;
                kind_d    = cmd_i.op;
                removed_d = '0;
                state_d   = S_DRAIN;
                if (cmd_i.op != OP_BATCH) begin
                  rem_d = LIM_W'(1);
                end else if (occ_q < CNT_W'(cmd_i.lim)) begin
                  rem_d = occ_q[LIM_W-1:0];
                end else begin
                  rem_d = cmd_i.lim;
                end
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_DRAIN: begin
        res_valid_d = 1'b1;
        word_d      = WORD_W'(rd_q);
        unique case (kind_q) inside
          OP_PEEK: begin
            state_d = S_IDLE;
          end
          OP_DEQ: begin
            head_d  = head_nxt;
            occ_d   = occ_q - CNT_W'(1);
            count_d = occ_q - CNT_W'(1);
            state_d = S_IDLE;
          end
          default: begin
            head_d = head_nxt;
            occ_d  = occ_q - CNT_W'(1);
            last_d = stop;
            if (stop) begin
              count_d = CNT_W'(removed_n);
              state_d = S_IDLE;
            end else begin
              count_d   = occ_q - CNT_W'(1);
              rem_d     = rem_q - LIM_W'(1);
              removed_d = removed_n;
              rd_en     = 1'b1;
              rd_addr   = head_nxt;
            end
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cfg_valid_i) begin
      cap_d  = cfg_data_i;
      head_d = '0;
      tail_d = '0;
      occ_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      kind_q      <= OP_SIZE;
      rem_q       <= '0;
      removed_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      kind_q      <= kind_d;
      rem_q       <= rem_d;
      removed_q   <= removed_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    word_q   <= word_d;
    count_q  <= count_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= word_i;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign res_valid_o = res_valid_q;
  assign status_o    = status_q;
  assign item_word_o = word_q;
  assign count_o     = count_q;
  assign last_o      = last_q;

endmodule

>>> src/bounded_ring_queue_batch_dequeue_top.sv
// Top level of the bounded ring queue with batch dequeue.
// Depends on brqbd_pkg, brqbd_front and brqbd_back.
//
//   channel   handshake                  payload
//   command   start / busy               opcode_i, push_word_i, batch_limit_i
//   config    cfg_valid_i / cfg_ready_o  cfg_data_i (capacity)
//   result    res_valid_o, one cycle     status_o, item_word_o, count_o, last_o
//
// A command passes a front-end command slot and the back-end result registers first.
// Enqueue, size query and every error result are handled in the idle state alone;
// dequeue and peek also pass the drain state (registered store read); a batch reads
// its first word in the idle state, then gives one word per cycle in the drain state.
// A two-entry command queue parts front and back; busy is high while it is full.
// Reset empties the queue and sets capacity to 256; results cannot be stalled.
module bounded_ring_queue_batch_dequeue_top import brqbd_pkg::*; #(
  parameter int unsigned DEPTH     = DEF_DEPTH,
  parameter int unsigned WORD_BITS = DEF_WORD_BITS,
  parameter int unsigned MAX_BATCH = DEF_MAX_BATCH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OPC_W-1:0]  opcode_i,
  input  logic [WORD_W-1:0] push_word_i,
  input  logic [LIM_W-1:0]  batch_limit_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CNT_W-1:0]  cfg_data_i,
  output logic              res_valid_o,
  output logic [STAT_W-1:0] status_o,
  output logic [WORD_W-1:0] item_word_o,
  output logic [CNT_W-1:0]  count_o,
  output logic              last_o
);

  logic                 cmd_valid, pop;
  cmd_t                 cmd;
  logic [WORD_BITS-1:0] cmd_word;

  assign cfg_ready_o = 1'b1;

  brqbd_front #(
    .WORD_BITS (WORD_BITS),
    .MAX_BATCH (MAX_BATCH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .opcode_i      (opcode_i),
    .push_word_i   (push_word_i),
    .batch_limit_i (batch_limit_i),
    .busy_o        (busy),
    .pop_i         (pop),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .word_o        (cmd_word)
  );

  brqbd_back #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .word_i      (cmd_word),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .status_o    (status_o),
    .item_word_o (item_word_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

endmodule

>>> src/brqbd_checker.sv
// Port-level checks for the bounded ring queue, bound to the top level.
// Depends on brqbd_pkg and bounded_ring_queue_batch_dequeue_top.
module brqbd_checker import brqbd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              res_valid_o,
  input logic [STAT_W-1:0] status_o,
  input logic [WORD_W-1:0] item_word_o,
  input logic [CNT_W-1:0]  count_o,
  input logic              last_o
);

  a_full_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o == ST_FULL |-> last_o && item_word_o == '0)
    else $error("full result not a single empty-word result");

  a_empty_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o == ST_EMPTY |-> last_o && count_o == '0 && item_word_o == '0)
    else $error("empty result malformed");

  a_batch_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |-> status_o == ST_OK)
    else $error("non-final result without ok status");

  a_batch_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |=> res_valid_o)
    else $error("batch transfer broke off before its last result");

endmodule

bind bounded_ring_queue_batch_dequeue_top brqbd_checker u_brqbd_checker (.*);

>>> test/bounded_ring_queue_batch_dequeue_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_ring_queue_batch_dequeue_top.
// Depends on brqbd_pkg and the RTL; mirrors the ring queue and checks every result transfer.
module bounded_ring_queue_batch_dequeue_top_tb;
  import brqbd_pkg::*;

  localparam int unsigned DEPTH       = DEF_DEPTH;
  localparam int unsigned MAX_BATCH   = DEF_MAX_BATCH;
  localparam int unsigned GAP_PCT     = 15;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned END_DRAIN   = 8;
  localparam int unsigned MAX_REPORTS = 100;

  localparam logic [OPC_W-1:0] OP_FIRST_UNUSED = OP_SIZE + 1'b1;
  localparam logic [OPC_W-1:0] OP_LAST_CODE    = '1;
  localparam logic [LIM_W-1:0] LIM_ALL_ONES    = '1;

  typedef struct packed {
    logic [OPC_W-1:0]  op;
    logic [WORD_W-1:0] word;
    logic [LIM_W-1:0]  lim;
  } cmd_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } queue_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OPC_W-1:0]  opcode_i = '0;
  logic [WORD_W-1:0] push_word_i = '0;
  logic [LIM_W-1:0]  batch_limit_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CNT_W-1:0]  cfg_data_i = '0;
  logic              res_valid_o;
  logic [STAT_W-1:0] status_o;
  logic [WORD_W-1:0] item_word_o;
  logic [CNT_W-1:0]  count_o;
  logic              last_o;

  cmd_item_t     cmd_q[$];
  queue_result_t awaited[$];
  logic          no_gaps = 1'b0;
  int unsigned   fault_count = 0;
  int unsigned   stall_cycles = 0;

  logic [WORD_W-1:0] mirror_store [DEPTH];
  int unsigned       mirror_head = 0;
  int unsigned       mirror_tail = 0;
  int unsigned       mirror_occ = 0;
  logic [CNT_W-1:0]  mirror_cap = CAP_RESET;

  bounded_ring_queue_batch_dequeue_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .push_word_i   (push_word_i),
    .batch_limit_i (batch_limit_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .res_valid_o   (res_valid_o),
    .status_o      (status_o),
    .item_word_o   (item_word_o),
    .count_o       (count_o),
    .last_o        (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned cap_in_use();
    if (mirror_cap == '0) return 1;
    if (mirror_cap > DEPTH) return DEPTH;
    return mirror_cap;
  endfunction

  function automatic int unsigned ring_next(int unsigned idx);
    return (idx + 1 >= cap_in_use()) ? 0 : idx + 1;
  endfunction

  function automatic void await_result(logic [STAT_W-1:0] st, logic [WORD_W-1:0] w,
                                       int unsigned cnt, logic last);
    queue_result_t r;
    r.status = st;
    r.word   = w;
    r.cnt    = CNT_W'(cnt);
    r.last   = last;
    awaited.push_back(r);
  endfunction

  function automatic logic [WORD_W-1:0] pop_head();
    logic [WORD_W-1:0] w;
    w = mirror_store[mirror_head];
    mirror_head = ring_next(mirror_head);
    mirror_occ--;
    return w;
  endfunction

  // Advance the queue mirror by one command and record the results it owes.
  function automatic void model_queue_op(logic [OPC_W-1:0] op, logic [WORD_W-1:0] word,
                                         logic [LIM_W-1:0] lim);
    int unsigned       take_max;
    int unsigned       removed;
    logic [WORD_W-1:0] w;
    logic              done;
    if (op == OP_ENQ) begin
      if (mirror_occ >= cap_in_use()) begin
        await_result(ST_FULL, '0, mirror_occ, 1'b1);
      end else begin
        mirror_store[mirror_tail] = word;
        mirror_tail = ring_next(mirror_tail);
        mirror_occ++;
        await_result(ST_OK, '0, mirror_occ, 1'b1);
      end
    end else if ((op == OP_DEQ || op == OP_PEEK || op == OP_BATCH) && mirror_occ == 0) begin
      await_result(ST_EMPTY, '0, 0, 1'b1);
    end else if (op == OP_DEQ) begin
      w = pop_head();
      await_result(ST_OK, w, mirror_occ, 1'b1);
    end else if (op == OP_PEEK) begin
      await_result(ST_OK, mirror_store[mirror_head], mirror_occ, 1'b1);
    end else if (op == OP_BATCH) begin
      if (lim == '0) begin
        await_result(ST_OK, '0, 0, 1'b1);
      end else begin
        take_max = (lim > MAX_BATCH) ? MAX_BATCH : lim;
        if (mirror_occ < take_max) take_max = mirror_occ;
        removed = 0;
        done = 1'b0;
        while (!done) begin
          w = pop_head();
          removed++;
          done = (w == '0) || (removed == take_max);
          if (done) await_result(ST_OK, w, removed, 1'b1);
          else      await_result(ST_OK, w, mirror_occ, 1'b0);
        end
      end
    end else begin
      await_result(ST_OK, '0, mirror_occ, 1'b1);
    end
  endfunction

  always @(posedge clk_i) begin : drive
    cmd_item_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) model_queue_op(opcode_i, push_word_i, batch_limit_i);
      if (cmd_q.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
        nxt = cmd_q.pop_front();
        opcode_i      <= nxt.op;
        push_word_i   <= nxt.word;
        batch_limit_i <= nxt.lim;
        start         <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    queue_result_t want;
    if (rst_ni && res_valid_o) begin
      if (awaited.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
          $write("%0t: unexpected result: expected none, ", $time);
          $display("actual status=%0d word=%h count=%0d last=%0d",
                   status_o, item_word_o, count_o, last_o);
        end
      end else begin
        want = awaited.pop_front();
        if (status_o !== want.status || item_word_o !== want.word ||
            count_o !== want.cnt || last_o !== want.last) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $write("%0t: mismatch: expected status=%0d word=%h count=%0d last=%0d, ",
                   $time, want.status, want.word, want.cnt, want.last);
            $display("actual status=%0d word=%h count=%0d last=%0d",
                     status_o, item_word_o, count_o, last_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic void add_cmd(logic [OPC_W-1:0] op, logic [WORD_W-1:0] word,
                                  logic [LIM_W-1:0] lim);
    cmd_item_t c;
    c.op   = op;
    c.word = word;
    c.lim  = lim;
    cmd_q.push_back(c);
  endfunction

  function automatic void add_random(int unsigned enq_pct);
    int unsigned       pick;
    logic [OPC_W-1:0]  op;
    logic [WORD_W-1:0] w;
    logic [LIM_W-1:0]  lim;
    w = {$urandom, $urandom};
    case ($urandom_range(7))
      0, 1:    w = '0;
      2:       w = '1;
      default: ;
    endcase
    lim = ($urandom_range(9) == 0) ? LIM_W'($urandom_range(LIM_ALL_ONES))
                                   : LIM_W'($urandom_range(8, 1));
    pick = $urandom_range(99);
    if (pick < enq_pct) begin
      op = OP_ENQ;
    end else begin
      pick = $urandom_range(99);
      if (pick < 30)      op = OP_DEQ;
      else if (pick < 45) op = OP_PEEK;
      else if (pick < 85) op = OP_BATCH;
      else if (pick < 95) op = OP_SIZE;
      else                op = OPC_W'($urandom_range(OP_LAST_CODE, OP_FIRST_UNUSED));
    end
    add_cmd(op, w, lim);
  endfunction

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || start || awaited.size() != 0);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] cap);
    @(posedge clk_i);
    cfg_data_i  <= cap;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mirror_cap  = cap;
    mirror_head = 0;
    mirror_tail = 0;
    mirror_occ  = 0;
    @(negedge clk_i);
  endtask

  task automatic random_phase(logic [CNT_W-1:0] cap, int unsigned n, int unsigned enq_pct);
    wait_quiet();
    write_capacity(cap);
    repeat (n) add_random(enq_pct);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty queue, spare opcodes, word extremes, batch stops and saturation
    add_cmd(OP_DEQ, '1, '0);
    add_cmd(OP_PEEK, '0, '1);
    add_cmd(OP_BATCH, '0, LIM_W'(5));
    add_cmd(OP_SIZE, '0, '0);
    add_cmd(OP_FIRST_UNUSED, '1, '1);
    add_cmd(OP_LAST_CODE, '0, '0);
    add_cmd(OP_ENQ, '1, '0);
    add_cmd(OP_ENQ, WORD_W'(1), '1);
    add_cmd(OP_ENQ, {1'b1, {(WORD_W-1){1'b0}}}, '0);
    add_cmd(OP_PEEK, '0, '0);
    add_cmd(OP_BATCH, '0, '0);
    add_cmd(OP_DEQ, '0, '0);
    add_cmd(OP_ENQ, '0, '0);
    add_cmd(OP_ENQ, {(WORD_W/8){8'hA5}}, '0);
    add_cmd(OP_BATCH, '0, LIM_ALL_ONES);
    add_cmd(OP_SIZE, '0, '0);
    add_cmd(OP_FIRST_UNUSED + 1'b1, '0, '0);
    add_cmd(OP_BATCH, '0, LIM_W'(1));
    add_cmd(OP_ENQ, {$urandom, $urandom}, '0);
    add_cmd(OP_ENQ, {$urandom, $urandom}, '0);
    add_cmd(OP_ENQ, {$urandom, $urandom}, '0);
    add_cmd(OP_BATCH, '0, LIM_W'(MAX_BATCH));

    // capacity one: full after a single word
    wait_quiet();
    write_capacity(CNT_W'(1));
    add_cmd(OP_ENQ, {$urandom, $urandom}, '0);
    add_cmd(OP_ENQ, {$urandom, $urandom}, '0);
    add_cmd(OP_PEEK, '0, '0);
    add_cmd(OP_SIZE, '0, '0);
    add_cmd(OP_BATCH, '0, LIM_W'(2));
    add_cmd(OP_DEQ, '0, '0);

    random_phase(CNT_W'(0), 20, 50);
    random_phase(CNT_W'(3), 40, 55);

    // capacity above the store depth: long stretch with no gaps, then drain
    wait_quiet();
    write_capacity('1);
    no_gaps <= 1'b1;
    repeat (40) begin
      add_cmd(OP_ENQ, ($urandom_range(15) == 0) ? '0 : {$urandom, $urandom}, '0);
    end
    repeat (20) add_random(20);
    wait_quiet();
    no_gaps <= 1'b0;

    random_phase(CNT_W'(DEPTH), 40, 60);
    random_phase(CNT_W'(17), 40, 55);

    wait_quiet();
    repeat (END_DRAIN) @(posedge clk_i);
    if (fault_count == 0 && awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
